FILE: hw/rtl/linear_interp_audio_resampler_defines.svh
// Assertion macros used by the resampler back end.
// Every macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef LINEAR_INTERP_AUDIO_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_AUDIO_RESAMPLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/lirs_pkg.sv
package lirs_pkg;

	// Frame layout.
	localparam int MAX_CH = 6;
	localparam int SMP_W  = 16;

	// Default fixed point split and counter width.
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;

	// Register widths.
	localparam int ACC_W  = 32;
	localparam int CHAN_W = 3;
	localparam int STEP_W = 24;
	localparam int OUTF_W = 16;

	// At most this many interpolated frames are released by one input frame.
	localparam int INTERP_CAP = 32;
	localparam int CAP_W      = $clog2(INTERP_CAP + 1);

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_CHANNELS   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OUT_FRAMES = 2'd2;

	// Register reset values.
	localparam logic [CHAN_W-1:0] CHANNELS_RST   = 3'd2;
	localparam logic [STEP_W-1:0] PHASE_STEP_RST = 24'h010000;
	localparam logic [OUTF_W-1:0] OUT_FRAMES_RST = 16'd1024;

	// Flipping the sign bit maps two's complement to offset binary and back.
	localparam logic [SMP_W-1:0] SIGN_FLIP = 16'h8000;

	// One frame of samples, one lane per channel.
	typedef logic [MAX_CH-1:0][SMP_W-1:0] lirs_frame_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [CHAN_W-1:0] channels;
		logic [STEP_W-1:0] phase_step;
		logic [OUTF_W-1:0] out_frames;
	} lirs_cfg_t;

endpackage

FILE: hw/rtl/lirs_fifo.sv
module lirs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Status flags come straight from the fill count.
	assign full     = (count_q == CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the depth; the count tracks push and pop together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/lirs_front.sv
module lirs_front import lirs_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  lirs_frame_t                            in_frame,
	input  logic                                   in_last,
	output logic                                   push,
	output logic [$bits(lirs_frame_t)+COUNT_BITS:0] push_data,
	input  logic                                   full
);

	logic [COUNT_BITS-1:0] index_q;
	lirs_frame_t           offset_frame;

	// A transaction is taken whenever the queue has room.
	assign in_stall = full;
	assign push     = in_valid && !full;

	// Samples travel in offset binary so that the blend is unsigned.
	always_comb begin
		for (int c = 0; c < MAX_CH; c++) begin
			offset_frame[c] = in_frame[c] ^ SIGN_FLIP;
		end
	end

	// Each frame is tagged with its place in the job.
	assign push_data = {offset_frame, in_last, index_q};

	// Frame index counter: wraps at its width, restarts after the last frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (push) begin
			index_q <= in_last ? '0 : index_q + COUNT_BITS'(1);
		end
	end

endmodule

FILE: hw/rtl/lirs_back.sv
`include "linear_interp_audio_resampler_defines.svh"

module lirs_back import lirs_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lirs_cfg_t             cfg,
	input  logic                  head_valid,
	input  lirs_frame_t           head_frame,
	input  logic                  head_last,
	input  logic [COUNT_BITS-1:0] head_index,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lirs_frame_t           out_frame,
	output logic                  out_last
);

	localparam int IDX_W  = ACC_W - FRAC_BITS;
	localparam int CMP_W  = (IDX_W > COUNT_BITS) ? IDX_W : COUNT_BITS;
	localparam int LIM_W  = (OUTF_W > COUNT_BITS) ? OUTF_W : COUNT_BITS;
	localparam int PROD_W = SMP_W + FRAC_BITS + 2;
	localparam logic [COUNT_BITS-1:0] COUNT_MASK = '1;

	logic [ACC_W-1:0]      acc_q;
	logic [COUNT_BITS-1:0] oe_q;
	logic [CAP_W-1:0]      cnt_q;
	lirs_frame_t           prev_q;
	logic                  out_valid_q;
	lirs_frame_t           out_frame_q;
	logic                  out_last_q;

	logic [IDX_W-1:0]     idx;
	logic [FRAC_BITS-1:0] frac;
	logic [FRAC_BITS-1:0] weight;
	logic [OUTF_W-1:0]    lim_raw;
	logic [LIM_W-1:0]     lim;
	logic                 idx_lt_n;
	logic                 below_lim;
	logic                 cap_hit;
	logic                 can_interp;
	logic                 slot_free;
	logic                 do_interp;
	logic                 do_final;
	logic                 do_skip;
	logic                 left_cur;
	lirs_frame_t          blended;

	// Split the accumulator into frame index and blend weight.
	assign idx  = acc_q[ACC_W-1:FRAC_BITS];
	assign frac = acc_q[FRAC_BITS-1:0];

	// Interpolated outputs stop one short of out_frames, held within the counter.
	assign lim_raw = (cfg.out_frames == '0) ? '0 : cfg.out_frames - OUTF_W'(1);
	assign lim     = (LIM_W'(lim_raw) > LIM_W'(COUNT_MASK)) ? LIM_W'(COUNT_MASK)
	                                                        : LIM_W'(lim_raw);

	// Decide what the head frame does this cycle.
	assign idx_lt_n   = (CMP_W'(idx) < CMP_W'(head_index));
	assign below_lim  = (LIM_W'(oe_q) < lim);
	assign cap_hit    = (cnt_q == CAP_W'(INTERP_CAP));
	assign can_interp = head_valid && below_lim && !cap_hit && (idx_lt_n || head_last);
	assign slot_free  = !out_valid_q || !out_stall;
	assign do_interp  = can_interp && slot_free;
	assign do_final   = head_valid && !can_interp && head_last && slot_free;
	assign do_skip    = head_valid && !can_interp && !head_last;
	assign pop        = do_final || do_skip;

	// Past the end of the job the current frame stands in for the left one;
	// the closing copy blends the current frame with itself at zero weight.
	assign left_cur = !can_interp || !idx_lt_n;
	assign weight   = can_interp ? frac : '0;

	// One multiplier lane per channel: a*2^F + (b-a)*t, then drop the fraction.
	for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
		logic [SMP_W-1:0]         left_smp;
		logic signed [SMP_W:0]    diff;
		logic signed [FRAC_BITS:0] tw;
		logic signed [PROD_W-1:0] prod;
		logic signed [PROD_W-1:0] base;
		logic signed [PROD_W-1:0] total;
		logic [SMP_W-1:0]         res;

		always_comb begin
			left_smp = left_cur ? head_frame[c] : prev_q[c];
			diff     = signed'({1'b0, head_frame[c]}) - signed'({1'b0, left_smp});
			tw       = signed'({1'b0, weight});
			prod     = diff * tw;
			base     = signed'(PROD_W'({left_smp, {FRAC_BITS{1'b0}}}));
			total    = base + prod;
			res      = total[FRAC_BITS+SMP_W-1:FRAC_BITS];
			blended[c] = (CHAN_W'(c) < cfg.channels) ? (res ^ SIGN_FLIP) : '0;
		end
	end

	// Job state: phase, output count, per-frame output count, held frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			oe_q   <= '0;
			cnt_q  <= '0;
			prev_q <= '0;
		end else begin
			if (do_interp) begin
				acc_q <= acc_q + ACC_W'(cfg.phase_step);
				oe_q  <= oe_q + COUNT_BITS'(1);
				cnt_q <= cnt_q + CAP_W'(1);
			end
			if (pop) begin
				cnt_q  <= '0;
				prev_q <= head_frame;
			end
			if (do_final) begin
				acc_q <= '0;
				oe_q  <= '0;
			end
		end
	end

	// Output register: loads when free, clears once its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_interp || do_final) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_interp || do_final) begin
			out_frame_q <= blended;
			out_last_q  <= do_final;
		end
	end

	assign out_valid = out_valid_q;
	assign out_frame = out_frame_q;
	assign out_last  = out_last_q;

	`LIRS_ASSERT_NOW(a_cap_bound, 1'b1, cnt_q <= CAP_W'(INTERP_CAP), "per-frame output count overran its cap")
	`LIRS_ASSERT_NEXT(a_final_clears, do_final, (acc_q == '0) && (oe_q == '0), "job end left phase or count set")
	`LIRS_ASSERT_NEXT(a_final_marked, do_final, out_valid_q && out_last_q, "closing frame not marked last")
	`LIRS_ASSERT_NEXT(a_pop_restarts, pop, cnt_q == '0, "per-frame output count not restarted")

endmodule

FILE: hw/rtl/linear_interp_audio_resampler.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    sample_ch0..sample_ch5, last_frame
// output    out_valid / out_stall  out_ch0..out_ch5, last_out
// config    wr_en                  wr_index, wr_data
//
// In the back end an input frame first releases its k interpolated frames
// (0 to 32) and is then retired in a step of its own; on the last frame of a job
// that step issues the closing copy instead of only retiring the frame.
// An accepted frame passes through the queue to the back end, and its results
// are presented from the output register, which the six multiplier lanes feed
// directly; it can load a new output frame as the held one is taken.
// Frames queue two deep up front; in_stall rises when the queue is full.
// A stalled output blocks new output frames, not the retiring of non-last frames.
// Reset restores the configuration defaults and clears all job state at once.
module linear_interp_audio_resampler import lirs_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [REG_IDX_W-1:0]    wr_index,
	input  logic [STEP_W-1:0]       wr_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [SMP_W-1:0] sample_ch0,
	input  logic signed [SMP_W-1:0] sample_ch1,
	input  logic signed [SMP_W-1:0] sample_ch2,
	input  logic signed [SMP_W-1:0] sample_ch3,
	input  logic signed [SMP_W-1:0] sample_ch4,
	input  logic signed [SMP_W-1:0] sample_ch5,
	input  logic                    last_frame,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SMP_W-1:0] out_ch0,
	output logic signed [SMP_W-1:0] out_ch1,
	output logic signed [SMP_W-1:0] out_ch2,
	output logic signed [SMP_W-1:0] out_ch3,
	output logic signed [SMP_W-1:0] out_ch4,
	output logic signed [SMP_W-1:0] out_ch5,
	output logic                    last_out
);

	localparam int ENTRY_W = $bits(lirs_frame_t) + COUNT_BITS + 1;

	lirs_cfg_t             cfg_q;
	lirs_frame_t           in_frame;
	logic                  push;
	logic [ENTRY_W-1:0]    push_data;
	logic                  full;
	logic                  pop;
	logic [ENTRY_W-1:0]    pop_data;
	logic                  head_valid;
	lirs_frame_t           head_frame;
	logic                  head_last;
	logic [COUNT_BITS-1:0] head_index;
	lirs_frame_t           out_frame;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels   <= CHANNELS_RST;
			cfg_q.phase_step <= PHASE_STEP_RST;
			cfg_q.out_frames <= OUT_FRAMES_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_CHANNELS: begin
					cfg_q.channels <= wr_data[CHAN_W-1:0];
				end
				REG_PHASE_STEP: begin
					cfg_q.phase_step <= wr_data;
				end
				REG_OUT_FRAMES: begin
					cfg_q.out_frames <= wr_data[OUTF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Gather the sample ports into one frame.
	assign in_frame[0] = sample_ch0;
	assign in_frame[1] = sample_ch1;
	assign in_frame[2] = sample_ch2;
	assign in_frame[3] = sample_ch3;
	assign in_frame[4] = sample_ch4;
	assign in_frame[5] = sample_ch5;

	lirs_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_frame  (in_frame),
		.in_last   (last_frame),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	lirs_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.valid     (head_valid)
	);

	// Unpack the queue head.
	assign {head_frame, head_last, head_index} = pop_data;

	lirs_back #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_frame (head_frame),
		.head_last  (head_last),
		.head_index (head_index),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_frame  (out_frame),
		.out_last   (last_out)
	);

	// Spread the result frame over the output ports.
	assign out_ch0 = signed'(out_frame[0]);
	assign out_ch1 = signed'(out_frame[1]);
	assign out_ch2 = signed'(out_frame[2]);
	assign out_ch3 = signed'(out_frame[3]);
	assign out_ch4 = signed'(out_frame[4]);
	assign out_ch5 = signed'(out_frame[5]);

endmodule
